@@ rtl/slm_pkg.sv @@
// shared constants, command codes and list control and status types for the sorted list merge
package slm_pkg;

  localparam int LIST_DEPTH = 32;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_APPEND_A = 2'd0,
    CMD_APPEND_B = 2'd1,
    CMD_MERGE    = 2'd2
  } slm_cmd_t;

  typedef struct packed {
    logic append;
    logic shift;
  } slm_list_ctl_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] head;
    logic [CNT_W-1:0]             count;
    logic                         full;
  } slm_list_sts_t;

endpackage

@@ rtl/sorted_list_merge.sv @@
// top level of the sorted list merge: command decode, merge sequencer and result register
//
// Each list is a row of LIST_DEPTH cells with its head in cell zero. An append
// request leaves busy low, so appends may come every cycle while no merge runs;
// an append to a full list is dropped and sets the sticky overflow flag. A
// merge request raises busy until every stored element has been taken:
// each cycle the two head cells are compared (list A wins a tie) and
// the chosen row shifts by one cell. Results are registered and appear in the
// cycle after their comparison, one per cycle with out_strobe high, the final
// one with out_last; the receiver cannot stall them. A merge of two empty lists
// gives no result. The merge empties both lists and clears the overflow flag.
module sorted_list_merge
  import slm_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_command,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  output logic                         out_strobe,
  output logic signed [DATA_WIDTH-1:0] out_merged_value,
  output logic                         out_from_b,
  output logic                         out_last,
  output logic                         out_overflow
);

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_t;

  state_t                       state_r;
  logic                         dropped_r;
  logic                         ovf_r;
  logic                         out_strobe_r;
  logic signed [DATA_WIDTH-1:0] out_value_r;
  logic                         out_from_b_r;
  logic                         out_last_r;
  logic                         out_overflow_r;

  slm_list_ctl_t ctl_a;
  slm_list_ctl_t ctl_b;
  slm_list_sts_t sts_a;
  slm_list_sts_t sts_b;

  logic             accept;
  slm_cmd_t         cmd;
  logic             merging;
  logic             take_b;
  logic             empty_a;
  logic             empty_b;
  logic             last_one;
  logic [CNT_W:0]   total;

  assign accept  = start && !busy;
  assign cmd     = slm_cmd_t'(in_command);
  assign merging = (state_r == ST_MERGE);
  assign busy    = merging;
  assign empty_a = (sts_a.count == '0);
  assign empty_b = (sts_b.count == '0);
  assign take_b  = empty_a || (!empty_b && (sts_b.head < sts_a.head));
  assign total   = (CNT_W+1)'(sts_a.count) + (CNT_W+1)'(sts_b.count);
  assign last_one = (total == (CNT_W+1)'(1));

  always_comb begin
    ctl_a = '0;
    ctl_b = '0;
    if (accept && (cmd == CMD_APPEND_A)) begin
      ctl_a.append = 1'b1;
    end
    if (accept && (cmd == CMD_APPEND_B)) begin
      ctl_b.append = 1'b1;
    end
    if (merging) begin
      ctl_a.shift = !take_b;
      ctl_b.shift = take_b;
    end
  end

  slm_list u_list_a (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl_a),
    .append_value (in_value),
    .sts          (sts_a)
  );

  slm_list u_list_b (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl_b),
    .append_value (in_value),
    .sts          (sts_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      dropped_r    <= 1'b0;
      ovf_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            case (cmd)
              CMD_APPEND_A: begin
                if (sts_a.full) begin
                  dropped_r <= 1'b1;
                end
              end
              CMD_APPEND_B: begin
                if (sts_b.full) begin
                  dropped_r <= 1'b1;
                end
              end
              CMD_MERGE: begin
                ovf_r     <= dropped_r;
                dropped_r <= 1'b0;
                if (total != '0) begin
                  state_r <= ST_MERGE;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_MERGE: begin
          out_strobe_r   <= 1'b1;
          out_value_r    <= take_b ? sts_b.head : sts_a.head;
          out_from_b_r   <= take_b;
          out_last_r     <= last_one;
          out_overflow_r <= ovf_r;
          if (last_one) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_merged_value = out_value_r;
  assign out_from_b       = out_from_b_r;
  assign out_last         = out_last_r;
  assign out_overflow     = out_overflow_r;

  a_merge_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    merging |-> (total != '0))
    else $error("merge running with both lists empty");

  a_strobe_after_merge: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(merging))
    else $error("result strobe without a merge cycle");

  a_last_ends_merge: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> (busy == !out_last_r))
    else $error("last mark and busy disagree");

  a_no_append_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    merging |-> (!ctl_a.append && !ctl_b.append))
    else $error("append during merge");

endmodule

@@ rtl/slm_cell.sv @@
// one storage cell of a list row: loads an appended word or takes its neighbor's word
module slm_cell
  import slm_pkg::*;
(
  input  logic                         clk,
  input  logic                         load,
  input  logic                         shift,
  input  logic signed [DATA_WIDTH-1:0] load_value,
  input  logic signed [DATA_WIDTH-1:0] next_value,
  output logic signed [DATA_WIDTH-1:0] value
);

  logic signed [DATA_WIDTH-1:0] value_r;

  always_ff @(posedge clk) begin
    if (load) begin
      value_r <= load_value;
    end else if (shift) begin
      value_r <= next_value;
    end
  end

  assign value = value_r;

endmodule

@@ rtl/slm_list.sv @@
// one list: a row of cells with a fill count, head at cell zero
module slm_list
  import slm_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  slm_list_ctl_t                ctl,
  input  logic signed [DATA_WIDTH-1:0] append_value,
  output slm_list_sts_t                sts
);

  logic [CNT_W-1:0]             count_r;
  logic [CNT_W-1:0]             count_nxt;
  logic                         full;
  logic signed [DATA_WIDTH-1:0] cell_q [LIST_DEPTH];

  assign full = (count_r == CNT_W'(LIST_DEPTH));

  genvar i;
  generate
    for (i = 0; i < LIST_DEPTH; i++) begin : g_cell
      logic signed [DATA_WIDTH-1:0] nxt_value;
      if (i == LIST_DEPTH - 1) begin : g_tail
        assign nxt_value = cell_q[i];
      end else begin : g_mid
        assign nxt_value = cell_q[i+1];
      end
      slm_cell u_cell (
        .clk        (clk),
        .load       (ctl.append && !full && (count_r == CNT_W'(i))),
        .shift      (ctl.shift),
        .load_value (append_value),
        .next_value (nxt_value),
        .value      (cell_q[i])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (ctl.append && !full) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.shift && (count_r != '0)) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign sts.head  = cell_q[0];
  assign sts.count = count_r;
  assign sts.full  = full;

endmodule
